[hw/rtl/mdps_pkg.sv]
// shared constants and word types for the minimum dot product block
package mdps_pkg;

  // store geometry
  localparam int MAX_PAIRS  = 64;
  localparam int VALUE_BITS = 8;
  localparam int IDX_W      = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CNT_W      = $clog2(MAX_PAIRS + 1);

  // result field widths
  localparam int SUM_W   = 22;
  localparam int COUNT_W = 7;
  localparam int PROD_W  = 2 * VALUE_BITS;
  localparam int ACC_W   = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

  // input word
  typedef struct packed {
    logic [VALUE_BITS-1:0] a_value;
    logic [VALUE_BITS-1:0] b_value;
    logic                  last_pair;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [SUM_W-1:0]   min_sum;
    logic [COUNT_W-1:0] pair_count;
    logic               overflow;
  } out_word_t;

endpackage

[hw/rtl/mdps_ram.sv]
// generic single write port ram with one registered read port
module mdps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/min_dot_product_by_sorting.sv]
// minimum dot product: load pairs, selection sort both lists in ram, sum of products
//
// channel  handshake            word                     direction
// in       start / busy         in_data  (in_word_t)     in
// out      out_valid (strobe)   out_data (out_word_t)    out
//
// each accepted start loads one word; words after the store is full are dropped
// and flagged. the word with last_pair set starts the compute, which holds busy
// through the whole compute: one ram read per cycle in the selection scan plus a
// tail state, two swap writes per position, then one multiply per pair and a
// drain of the multiply-accumulate.
// reset is synchronous and clears count, drop flag and control; the stores are
// not cleared. the result strobe lasts one cycle and cannot be stalled.
module min_dot_product_by_sorting (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mdps_pkg::in_word_t in_data,
  output logic               out_valid,
  output mdps_pkg::out_word_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SCAN_TAIL, S_SWAP1, S_SWAP2, S_ACC, S_DRAIN
  } state_t;

  state_t state_r;

  logic [mdps_pkg::CNT_W-1:0]      cnt_r;
  logic [mdps_pkg::CNT_W-1:0]      n_r;
  logic                            drop_r;
  logic [mdps_pkg::IDX_W-1:0]      i_r;
  logic [mdps_pkg::IDX_W-1:0]      j_r;
  logic [mdps_pkg::IDX_W-1:0]      rj_r;
  logic                            rv_r;
  logic                            mv_r;
  logic [mdps_pkg::VALUE_BITS-1:0] cur_a_r, best_a_r, cur_b_r, best_b_r;
  logic [mdps_pkg::IDX_W-1:0]      bi_a_r, bi_b_r;
  logic [mdps_pkg::PROD_W-1:0]     prod_r;
  logic [mdps_pkg::SUM_W-1:0]      sum_r;

  logic                            accept;
  logic                            has_room;
  logic [mdps_pkg::CNT_W-1:0]      n_new;
  logic [mdps_pkg::CNT_W-1:0]      n_m1;
  logic [mdps_pkg::IDX_W-1:0]      last_idx;
  logic [mdps_pkg::IDX_W-1:0]      i_inc;
  logic [mdps_pkg::ACC_W-1:0]      acc_sum;
  logic [mdps_pkg::SUM_W-1:0]      sat_sum;

  logic                            we_a, we_b;
  logic [mdps_pkg::IDX_W-1:0]      waddr_a, waddr_b;
  logic [mdps_pkg::VALUE_BITS-1:0] wdata_a, wdata_b;
  logic [mdps_pkg::VALUE_BITS-1:0] rd_a, rd_b;

  // handshake and load bookkeeping
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign has_room = (cnt_r < mdps_pkg::CNT_W'(mdps_pkg::MAX_PAIRS));
  assign n_new    = has_room ? cnt_r + mdps_pkg::CNT_W'(1) : cnt_r;
  assign n_m1     = n_r - mdps_pkg::CNT_W'(1);
  assign last_idx = n_m1[mdps_pkg::IDX_W-1:0];
  assign i_inc    = i_r + mdps_pkg::IDX_W'(1);

  // saturating accumulate of the registered product
  assign acc_sum = mdps_pkg::ACC_W'(sum_r) + mdps_pkg::ACC_W'(prod_r);
  assign sat_sum = (acc_sum > mdps_pkg::ACC_W'({mdps_pkg::SUM_W{1'b1}}))
                   ? {mdps_pkg::SUM_W{1'b1}} : acc_sum[mdps_pkg::SUM_W-1:0];

  // ram write port steering: load, then the two swap writes
  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr_a = cnt_r[mdps_pkg::IDX_W-1:0];
    waddr_b = cnt_r[mdps_pkg::IDX_W-1:0];
    wdata_a = in_data.a_value;
    wdata_b = in_data.b_value;
    case (state_r)
      S_IDLE: begin
        we_a = accept && has_room;
        we_b = accept && has_room;
      end
      S_SWAP1: begin
        we_a    = 1'b1;
        we_b    = 1'b1;
        waddr_a = bi_a_r;
        waddr_b = bi_b_r;
        wdata_a = cur_a_r;
        wdata_b = cur_b_r;
      end
      S_SWAP2: begin
        we_a    = 1'b1;
        we_b    = 1'b1;
        waddr_a = i_r;
        waddr_b = i_r;
        wdata_a = best_a_r;
        wdata_b = best_b_r;
      end
      default: begin
        we_a = 1'b0;
        we_b = 1'b0;
      end
    endcase
  end

  mdps_ram #(
    .WIDTH(mdps_pkg::VALUE_BITS),
    .DEPTH(mdps_pkg::MAX_PAIRS)
  ) u_ram_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr_a),
    .wdata(wdata_a),
    .raddr(j_r),
    .rdata(rd_a)
  );

  mdps_ram #(
    .WIDTH(mdps_pkg::VALUE_BITS),
    .DEPTH(mdps_pkg::MAX_PAIRS)
  ) u_ram_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr_b),
    .wdata(wdata_b),
    .raddr(j_r),
    .rdata(rd_b)
  );

  // sequencer, compare unit, multiply-accumulate and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      rv_r      <= 1'b0;
      mv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      rv_r      <= 1'b0;
      mv_r      <= rv_r && (state_r == S_ACC || state_r == S_DRAIN);

      // selection scan: first read gives the current entry, later reads the extremes
      if (rv_r && (state_r == S_SCAN || state_r == S_SCAN_TAIL)) begin
        if (rj_r == i_r) begin
          cur_a_r  <= rd_a;
          best_a_r <= rd_a;
          bi_a_r   <= rj_r;
          cur_b_r  <= rd_b;
          best_b_r <= rd_b;
          bi_b_r   <= rj_r;
        end else begin
          if (rd_a < best_a_r) begin
            best_a_r <= rd_a;
            bi_a_r   <= rj_r;
          end
          if (rd_b > best_b_r) begin
            best_b_r <= rd_b;
            bi_b_r   <= rj_r;
          end
        end
      end

      // multiply stage feeds the accumulate stage
      if (rv_r) begin
        prod_r <= mdps_pkg::PROD_W'(rd_a) * mdps_pkg::PROD_W'(rd_b);
      end
      if (mv_r) begin
        sum_r <= sat_sum;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (has_room) begin
              cnt_r <= cnt_r + mdps_pkg::CNT_W'(1);
            end else begin
              drop_r <= 1'b1;
            end
            if (in_data.last_pair) begin
              n_r   <= n_new;
              i_r   <= '0;
              j_r   <= '0;
              sum_r <= '0;
              if (n_new == mdps_pkg::CNT_W'(1)) begin
                state_r <= S_ACC;
              end else begin
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          rv_r <= 1'b1;
          rj_r <= j_r;
          j_r  <= j_r + mdps_pkg::IDX_W'(1);
          if (j_r == last_idx) begin
            state_r <= S_SCAN_TAIL;
          end
        end
        S_SCAN_TAIL: begin
          state_r <= S_SWAP1;
        end
        S_SWAP1: begin
          state_r <= S_SWAP2;
        end
        S_SWAP2: begin
          i_r <= i_inc;
          if (i_inc == last_idx) begin
            j_r     <= '0;
            state_r <= S_ACC;
          end else begin
            j_r     <= i_inc;
            state_r <= S_SCAN;
          end
        end
        S_ACC: begin
          rv_r <= 1'b1;
          j_r  <= j_r + mdps_pkg::IDX_W'(1);
          if (j_r == last_idx) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rv_r && !mv_r) begin
            out_valid           <= 1'b1;
            out_data.min_sum    <= sum_r;
            out_data.pair_count <= mdps_pkg::COUNT_W'(n_r);
            out_data.overflow   <= drop_r;
            cnt_r               <= '0;
            drop_r              <= 1'b0;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a last word always starts a compute
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_pair |=> busy)
    else $error("last word did not start compute");

  // a result is only produced at the end of a compute
  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result outside compute end");

  // reported count is never zero and never above capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pair_count != '0) &&
                  (n_r <= mdps_pkg::CNT_W'(mdps_pkg::MAX_PAIRS)))
    else $error("pair count out of range");

  // the fill count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mdps_pkg::CNT_W'(mdps_pkg::MAX_PAIRS))
    else $error("fill count beyond capacity");
`endif

endmodule

[tb/sv/min_dot_product_by_sorting_tb.sv]
// testbench for the minimum dot product block: pair sets in, checked sums out
`timescale 1ns / 100ps

module min_dot_product_by_sorting_tb;

  // compute time for a full store, counted from the block's scan, swap, multiply and drain states
  localparam int FULL_COMPUTE   =
    mdps_pkg::MAX_PAIRS * (mdps_pkg::MAX_PAIRS + 9) / 2 - 1;
  localparam int DRAIN_CYCLES   = FULL_COMPUTE + 20;
  localparam int WATCHDOG_LIMIT = 4 * FULL_COMPUTE + 1000;
  localparam int VALUE_LEVELS   = 1 << mdps_pkg::VALUE_BITS;
  localparam longint SUM_CEILING = (64'd1 << mdps_pkg::SUM_W) - 1;
  localparam int WORD_GOAL      = 1500;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  mdps_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  mdps_pkg::out_word_t out_data;

  // words waiting to be sent and sums waiting to come back
  mdps_pkg::in_word_t  pending_words[$];
  mdps_pkg::out_word_t expected_sums[$];

  // predictor state: value histograms stand in for the two stores
  int   a_hist[VALUE_LEVELS];
  int   b_hist[VALUE_LEVELS];
  int   held_pairs = 0;
  logic pairs_dropped = 1'b0;

  int word_total = 0;
  int words_taken = 0;
  int check_errors = 0;
  int quiet_cycles = 0;

  min_dot_product_by_sorting dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // store one pair; on the last pair pair smallest a with largest b and sum
  task automatic load_pair(input mdps_pkg::in_word_t w);
    mdps_pkg::out_word_t r;
    longint              total;
    int                  ia;
    int                  ib;
    if (held_pairs < mdps_pkg::MAX_PAIRS) begin
      a_hist[w.a_value]++;
      b_hist[w.b_value]++;
      held_pairs++;
    end else begin
      pairs_dropped = 1'b1;
    end
    if (w.last_pair) begin
      total = 0;
      ia = 0;
      ib = VALUE_LEVELS - 1;
      for (int k = 0; k < held_pairs; k++) begin
        while (a_hist[ia] == 0) ia++;
        while (b_hist[ib] == 0) ib--;
        total += longint'(ia) * longint'(ib);
        a_hist[ia]--;
        b_hist[ib]--;
      end
      r.min_sum    = (total > SUM_CEILING) ? '1 : total[mdps_pkg::SUM_W-1:0];
      r.pair_count = held_pairs[mdps_pkg::COUNT_W-1:0];
      r.overflow   = pairs_dropped;
      expected_sums.push_back(r);
      held_pairs    = 0;
      pairs_dropped = 1'b0;
    end
  endtask

  task automatic push_word(input int a, input int b, input bit last);
    mdps_pkg::in_word_t w;
    w.a_value   = a[mdps_pkg::VALUE_BITS-1:0];
    w.b_value   = b[mdps_pkg::VALUE_BITS-1:0];
    w.last_pair = last;
    pending_words.push_back(w);
  endtask

  // mostly full-range values, with the extremes favored
  function automatic int pick_value();
    case ($urandom_range(9))
      0: return 0;
      1: return VALUE_LEVELS - 1;
      2: return $urandom_range(3);
      default: return $urandom_range(VALUE_LEVELS - 1);
    endcase
  endfunction

  // sender idle chance per phase; the receiver cannot stall, so no phase for it
  function automatic int idle_pct();
    case ((words_taken * 4) / ((word_total > 0) ? word_total : 1))
      1: return 49;
      3: return 28;
      default: return 0;
    endcase
  endfunction

  // driver: present the next word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        load_pair(in_data);
        words_taken++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct()) begin
          start   <= 1'b1;
          in_data <= pending_words.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each strobed result against the oldest expected sum
  always @(posedge clk) begin
    mdps_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result: min_sum %0d pair_count %0d overflow %0d",
                 $time, out_data.min_sum, out_data.pair_count, out_data.overflow);
        check_errors++;
      end else begin
        want = expected_sums.pop_front();
        if (out_data.min_sum !== want.min_sum) begin
          $display("%0t: min_sum expected %0d, got %0d",
                   $time, want.min_sum, out_data.min_sum);
          check_errors++;
        end
        if (out_data.pair_count !== want.pair_count) begin
          $display("%0t: pair_count expected %0d, got %0d",
                   $time, want.pair_count, out_data.pair_count);
          check_errors++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0d, got %0d",
                   $time, want.overflow, out_data.overflow);
          check_errors++;
        end
      end
    end
  end

  // watchdog on cycles with neither a word taken nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int set_len;
    int pick;
    int forced_sets;
    for (int v = 0; v < VALUE_LEVELS; v++) begin
      a_hist[v] = 0;
      b_hist[v] = 0;
    end

    // directed: single pairs at the extremes
    push_word(0, 0, 1'b1);
    push_word(255, 255, 1'b1);
    push_word(0, 255, 1'b1);
    // small set where sorting matters
    push_word(1, 2, 1'b0);
    push_word(3, 4, 1'b0);
    push_word(5, 6, 1'b1);
    // alternating bit patterns
    push_word(8'hAA, 8'h55, 1'b0);
    push_word(8'h55, 8'hAA, 1'b0);
    push_word(8'hFF, 8'h01, 1'b0);
    push_word(8'h80, 8'h7F, 1'b1);
    // duplicates
    push_word(7, 7, 1'b0);
    push_word(7, 7, 1'b0);
    push_word(7, 7, 1'b1);
    // extremes crossed
    push_word(255, 0, 1'b0);
    push_word(0, 255, 1'b0);
    push_word(255, 255, 1'b1);

    // random sets: a full store, a dropped last pair, a longer overrun, then mixed
    forced_sets = 0;
    while (pending_words.size() < WORD_GOAL) begin
      case (forced_sets)
        0: set_len = mdps_pkg::MAX_PAIRS;
        1: set_len = mdps_pkg::MAX_PAIRS + 1;
        2: set_len = mdps_pkg::MAX_PAIRS + 8;
        default: begin
          pick = $urandom_range(99);
          if (pick < 80) set_len = $urandom_range(12, 1);
          else if (pick < 95) set_len = $urandom_range(mdps_pkg::MAX_PAIRS, 13);
          else set_len = $urandom_range(mdps_pkg::MAX_PAIRS + 8,
                                        mdps_pkg::MAX_PAIRS + 1);
        end
      endcase
      forced_sets++;
      for (int k = 1; k <= set_len; k++)
        push_word(pick_value(), pick_value(), k == set_len);
    end
    word_total = pending_words.size();

    // reset once, then let the driver run
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken < word_total || expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (check_errors == 0 && expected_sums.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
